// File: rtl/force_level_led_bar_animator_macros.svh
// Assertion macros for the LED bar animator.
// Included by the top level; compiles to nothing when SYNTHESIS is defined.
`ifndef FORCE_LEVEL_LED_BAR_ANIMATOR_MACROS_SVH
`define FORCE_LEVEL_LED_BAR_ANIMATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define FLBA_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define FLBA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FLBA_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define FLBA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/flba_pkg.sv
// Shared types, register indexes and reset constants of the LED bar animator.
// No dependencies; used by every RTL file of the block.
package flba_pkg;

	localparam int NUM_THRESH = 5;
	localparam int SAMPLE_W   = 14;
	localparam int LED_W      = 5;
	localparam int PIN_W      = 5;
	localparam int LEVEL_W    = 3;
	localparam int POS_W      = 3;
	localparam int TICK_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_THRESH_1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_4 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_5 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE    = 3'd6;

	typedef logic [SAMPLE_W-1:0] thresh_t;
	typedef thresh_t [NUM_THRESH-1:0] thresh_arr_t;

	localparam thresh_arr_t THRESH_RESET = {14'd14750, 14'd14250, 14'd13500, 14'd12000, 14'd9000};
	localparam logic [TICK_W-1:0] HOLD_RESET  = 8'd8;
	localparam logic [TICK_W-1:0] PULSE_RESET = 8'd2;

	typedef struct packed {
		logic                opcode;
		logic [1:0]          channel;
		logic [SAMPLE_W-1:0] sample;
		logic                side;
	} in_item_t;

	typedef struct packed {
		logic [LED_W-1:0]   led_mask;
		logic [PIN_W-1:0]   event_pins;
		logic [LEVEL_W-1:0] sample_level;
	} out_item_t;

	// LED and pin picture after the item leaving stage one is applied.
	typedef struct packed {
		logic [LED_W-1:0] lit;
		logic [PIN_W-1:0] pins;
	} anim_view_t;

	// Number of bar LEDs that really exist: at most one per threshold.
	function automatic int bar_leds(int num_leds);
		return (num_leds < NUM_THRESH) ? num_leds : NUM_THRESH;
	endfunction

	function automatic logic [LED_W-1:0] bar_mask(int num_leds);
		return LED_W'((32'd1 << bar_leds(num_leds)) - 32'd1);
	endfunction

endpackage

// File: rtl/flba_level.sv
// Threshold compare: turns one sample into a bar level.
// Depends on flba_pkg.
module flba_level #(
	parameter int LED_COUNT   = 5,
	parameter int SAMPLE_BITS = 14
) (
	input  flba_pkg::thresh_arr_t             thr,
	input  logic [flba_pkg::SAMPLE_W-1:0]     sample,
	output logic [flba_pkg::LEVEL_W-1:0]      level
);

	localparam int BarLeds = flba_pkg::bar_leds(LED_COUNT);
	localparam int UsedBits = (SAMPLE_BITS < flba_pkg::SAMPLE_W) ? SAMPLE_BITS
		: flba_pkg::SAMPLE_W;
	localparam logic [flba_pkg::SAMPLE_W-1:0] SampleMask =
		flba_pkg::SAMPLE_W'((32'd1 << UsedBits) - 32'd1);

	logic [flba_pkg::SAMPLE_W-1:0] s;

	assign s = sample & SampleMask;

	// Count leading thresholds passed; stop at the first one failed.
	always_comb begin
		logic                         run;
		logic [flba_pkg::LEVEL_W-1:0] lvl;
		run = 1'b1;
		lvl = '0;
		for (int k = 0; k < flba_pkg::NUM_THRESH; k++) begin
			run = run && (k < BarLeds) && (s > thr[k]);
			lvl = lvl + {{(flba_pkg::LEVEL_W-1){1'b0}}, run};
		end
		level = lvl;
	end

endmodule

// File: rtl/flba_anim.sv
// Bar animation and event pin state, updated once per item.
// Depends on flba_pkg.
module flba_anim #(
	parameter int LED_COUNT = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  flba_pkg::in_item_t             item,
	input  logic [flba_pkg::LEVEL_W-1:0]   level,
	input  logic [flba_pkg::TICK_W-1:0]    hold_ticks,
	input  logic [flba_pkg::TICK_W-1:0]    pulse_ticks,
	output flba_pkg::anim_view_t           view
);

	localparam logic [flba_pkg::LED_W-1:0] BarMask = flba_pkg::bar_mask(LED_COUNT);

	logic [flba_pkg::LEVEL_W-1:0] lvl_q, n_lvl;
	logic [flba_pkg::POS_W-1:0]   pos_q, n_pos;
	logic                         armed_q, n_armed;
	logic                         falling_q, n_falling;
	logic [flba_pkg::TICK_W-1:0]  hold_q, n_hold;
	logic [flba_pkg::TICK_W-1:0]  pc_q, n_pc;
	logic [flba_pkg::LED_W-1:0]   lit_q, n_lit;
	logic [flba_pkg::PIN_W-1:0]   pins_q, n_pins;

	logic [flba_pkg::LED_W-1:0]   pos_bit;
	logic [2:0]                   pin_idx;
	logic [flba_pkg::PIN_W-1:0]   pin_bit;

	// Indexes past the bar select nothing.
	assign pos_bit = flba_pkg::LED_W'(8'd1 << pos_q) & BarMask;
	assign pin_idx = (item.channel == 2'd0) ? {2'b00, item.side}
		: ({1'b0, item.channel} + 3'd1);
	assign pin_bit = flba_pkg::PIN_W'(8'd1 << pin_idx);

	always_comb begin
		n_lvl     = lvl_q;
		n_pos     = pos_q;
		n_armed   = armed_q;
		n_falling = falling_q;
		n_hold    = hold_q;
		n_pc      = pc_q;
		n_lit     = lit_q;
		n_pins    = pins_q;
		if (item.opcode == flba_pkg::OP_TICK) begin
			// Pulse countdown: release all pins as it expires.
			if (pc_q != '0) begin
				if (pc_q > 8'd1) begin
					n_pc = pc_q - 8'd1;
				end else begin
					n_pins = '0;
					n_pc   = '0;
				end
			end
			if (armed_q || falling_q) begin
				if (!falling_q) begin
					if ({1'b0, pos_q} < {1'b0, lvl_q}) begin
						n_lit = lit_q | pos_bit;
						n_pos = pos_q + 3'd1;
					end else begin
						n_falling = 1'b1;
						n_armed   = 1'b0;
					end
				end else if (armed_q) begin
					// New hit during the fall: clear and rise again.
					n_lit     = '0;
					n_falling = 1'b0;
					n_pos     = '0;
				end else if (hold_q != '0) begin
					n_hold = hold_q - 8'd1;
				end else begin
					n_lit = lit_q & ~pos_bit;
					if (pos_q == '0) begin
						n_falling = 1'b0;
						n_hold    = hold_ticks;
					end else begin
						n_pos = pos_q - 3'd1;
					end
				end
			end
		end else if (level != '0) begin
			n_armed = 1'b1;
			n_lvl   = level;
			n_pins  = pins_q | pin_bit;
			n_pc    = pulse_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q     <= '0;
			pos_q     <= '0;
			armed_q   <= 1'b0;
			falling_q <= 1'b0;
			hold_q    <= flba_pkg::HOLD_RESET;
			pc_q      <= '0;
			lit_q     <= '0;
			pins_q    <= '0;
		end else if (en) begin
			lvl_q     <= n_lvl;
			pos_q     <= n_pos;
			armed_q   <= n_armed;
			falling_q <= n_falling;
			hold_q    <= n_hold;
			pc_q      <= n_pc;
			lit_q     <= n_lit;
			pins_q    <= n_pins;
		end
	end

	assign view.lit  = n_lit;
	assign view.pins = n_pins;

endmodule

// File: rtl/force_level_led_bar_animator.sv
// Force-level LED bar animator: top level with config registers and pipeline.
// Depends on flba_pkg, flba_level, flba_anim and the assertion macro header.
//
// Usage:
//   in_*   : one beat is a force sample (opcode 0) or a timer tick (opcode 1).
//   out_*  : exactly one beat per input beat, in order: LED mask and event pins
//            after that beat is applied, plus the level of the sample (0 on tick).
//   cfg_*  : register writes (index 0..4 thresholds, 5 hold ticks, 6 pulse
//            ticks); cfg_ready is always high. Write only while the block is idle.
// Path from input beat to output beat: input register, then threshold compare
//   and animation update into the output register.
// Throughput: one beat per cycle while out_ready is high; the single animation
//   state update per beat is the only loop.
// Stall: when the receiver holds out_ready low, the output register holds its
//   beat, the input register still takes one more beat if empty, then in_ready drops.
// Reset: arst_n clears the valid flags of both pipeline stages, the animation
//   state and the event pins, and loads the register reset values.
`include "force_level_led_bar_animator_macros.svh"

module force_level_led_bar_animator #(
	parameter int LED_COUNT   = 5,
	parameter int SAMPLE_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  flba_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output flba_pkg::out_item_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [flba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [flba_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int BarLeds = flba_pkg::bar_leds(LED_COUNT);
	localparam logic [flba_pkg::LED_W-1:0] BarMask = flba_pkg::bar_mask(LED_COUNT);

	// Configuration registers.
	flba_pkg::thresh_arr_t            thr_q;
	logic [flba_pkg::TICK_W-1:0]      hold_ticks_q;
	logic [flba_pkg::TICK_W-1:0]      pulse_ticks_q;

	// Stage one: input register. Stage two: output register.
	logic                             valid_s1;
	flba_pkg::in_item_t               item_s1;
	logic                             out_valid_q;
	flba_pkg::out_item_t              out_q;

	logic                             adv_s2;
	logic                             load_s2;
	logic [flba_pkg::LEVEL_W-1:0]     level;
	flba_pkg::anim_view_t             view;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= flba_pkg::THRESH_RESET;
			hold_ticks_q  <= flba_pkg::HOLD_RESET;
			pulse_ticks_q <= flba_pkg::PULSE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				flba_pkg::REG_THRESH_1: thr_q[0] <= cfg_data;
				flba_pkg::REG_THRESH_2: thr_q[1] <= cfg_data;
				flba_pkg::REG_THRESH_3: thr_q[2] <= cfg_data;
				flba_pkg::REG_THRESH_4: thr_q[3] <= cfg_data;
				flba_pkg::REG_THRESH_5: thr_q[4] <= cfg_data;
				flba_pkg::REG_HOLD:     hold_ticks_q  <= cfg_data[flba_pkg::TICK_W-1:0];
				flba_pkg::REG_PULSE:    pulse_ticks_q <= cfg_data[flba_pkg::TICK_W-1:0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	// Advance stage two when the output register is empty or being drained;
	// stage one refills whenever it is empty or moves on.
	assign adv_s2   = !out_valid_q || out_ready;
	assign load_s2  = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset: it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	flba_level #(
		.LED_COUNT   (LED_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_level (
		.thr    (thr_q),
		.sample (item_s1.sample),
		.level  (level)
	);

	flba_anim #(
		.LED_COUNT (LED_COUNT)
	) u_anim (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (load_s2),
		.item        (item_s1),
		.level       (level),
		.hold_ticks  (hold_ticks_q),
		.pulse_ticks (pulse_ticks_q),
		.view        (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= valid_s1;
		end
	end

	// Capture the state after this beat; a tick reports level zero.
	always_ff @(posedge clk) begin
		if (load_s2) begin
			out_q.led_mask     <= view.lit;
			out_q.event_pins   <= view.pins;
			out_q.sample_level <= (item_s1.opcode == flba_pkg::OP_TICK) ? '0 : level;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`FLBA_ASSERT_IMPLY(a_led_in_bar, clk, arst_n, out_valid_q, (out_q.led_mask & ~BarMask) == '0, "LED lit outside the bar")
	`FLBA_ASSERT_IMPLY(a_level_cap, clk, arst_n, out_valid_q, out_q.sample_level <= flba_pkg::LEVEL_W'(BarLeds), "level above bar length")
	`FLBA_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && out_valid_q && !out_ready, "input stalled without full pipe")
	`FLBA_ASSERT_NEXT(a_stage_moves, clk, arst_n, valid_s1 && !out_valid_q, out_valid_q, "stage one beat not moved to output")

endmodule
